[rtl/nfd_pkg.sv]
// -----------------------------------------------------------------------------
// nfd_pkg
// Shared types and constants for the large-page NAND flash device model.
// -----------------------------------------------------------------------------
package nfd_pkg;

   // Default geometry
   localparam int NUM_PAGES_DEF        = 1024;
   localparam int PAGE_DATA_BYTES_DEF  = 2048;
   localparam int PAGE_TOTAL_BYTES_DEF = 2112;
   localparam int PAGES_PER_BLOCK_DEF  = 64;

   // Bus access kinds carried on req_tuser
   typedef enum logic [1:0] {
      BUS_CMD   = 2'd0,
      BUS_ADDR  = 2'd1,
      BUS_WRITE = 2'd2,
      BUS_READ  = 2'd3
   } bus_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_READ,
      MODE_RDOUT,
      MODE_PROG,
      MODE_RDIN,
      MODE_ERASE,
      MODE_STATUS,
      MODE_ID
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_PV_RD,
      ST_PV_CHK,
      ST_PROG,
      ST_PROG_LAST,
      ST_ERASE,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_WR_DIV,
      ST_WR_SUB
   } state_type;

   // Command bytes
   localparam logic [7:0] OP_RESET      = 8'hFF;
   localparam logic [7:0] OP_READ1      = 8'h00;
   localparam logic [7:0] OP_READ2      = 8'h30;
   localparam logic [7:0] OP_RND_OUT1   = 8'h05;
   localparam logic [7:0] OP_RND_OUT2   = 8'hE0;
   localparam logic [7:0] OP_PROG1      = 8'h80;
   localparam logic [7:0] OP_PROG2      = 8'h10;
   localparam logic [7:0] OP_PROG_CACHE = 8'h15;
   localparam logic [7:0] OP_RND_IN     = 8'h85;
   localparam logic [7:0] OP_ERASE1     = 8'h60;
   localparam logic [7:0] OP_ERASE2     = 8'hD0;
   localparam logic [7:0] OP_STATUS     = 8'h70;
   localparam logic [7:0] OP_READ_ID    = 8'h90;

   // Register indexes
   localparam logic [1:0] CSR_MAKER_ID   = 2'd0;
   localparam logic [1:0] CSR_DEVICE_ID  = 2'd1;
   localparam logic [1:0] CSR_HIDE_SPARE = 2'd2;

   localparam logic [7:0] MAKER_ID_RST  = 8'hEC;
   localparam logic [7:0] DEVICE_ID_RST = 8'hF1;
   localparam logic [7:0] STATUS_RST    = 8'hC0;
   localparam logic [7:0] STATUS_READY  = 8'h40;
   localparam logic [7:0] STATUS_WP     = 8'h80;
   localparam logic [7:0] STATUS_MASK   = 8'hC1;
   localparam logic [7:0] ID_BYTE3      = 8'h15;
   localparam logic [7:0] ERASED        = 8'hFF;
   localparam logic [2:0] ADDR_CYC_MAX  = 3'd7;
   localparam logic [2:0] ADDR_CYC_ROW  = 3'd4;

   localparam logic [15:0] ID_IDX_MAKER  = 16'd0;
   localparam logic [15:0] ID_IDX_DEVICE = 16'd1;
   localparam logic [15:0] ID_IDX_BYTE3  = 16'd3;
   localparam logic [15:0] COL_MAX       = 16'hFFFF;

endpackage

[rtl/nfd_ram.sv]
// -----------------------------------------------------------------------------
// nfd_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module nfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

[rtl/nand_flash_device_model.sv]
// -----------------------------------------------------------------------------
// nand_flash_device_model
// Large-page NAND flash chip model: command, address, data-in and data-out
// bus accesses against a flash array, a page buffer and a page-valid map.
// -----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                      Transfer when
//  req_     in   tuser: cmd[1:0]; tdata: byte_in[7:0]          tvalid & tready
//  rsp_     out  tdata: read_data[7:0], ready_res[8], pad 0    tvalid & tready
//  csr_     in   addr: register index; wdata: value[7:0]      we
//
// Command, address, status and ID accesses answer from idle; array reads
// go through the row base multiply, the array read and the result; data
// writes through a reciprocal multiply, then the buffer write; 80h presets
// the page buffer to 0xFF; program reads the page-valid bit, then makes one
// array read-modify-write per cycle; erase clears up to PAGES_PER_BLOCK
// entries of the page-valid map. Erased pages are tracked in a page-valid
// map: a page whose bit is clear reads 0xFF, so erase never touches the array.
// After reset a clearing pass walks the page-valid map with req_tready low.
// One result per request; a new request is taken while the previous result
// is being taken on the same edge.
// -----------------------------------------------------------------------------
module nand_flash_device_model
   import nfd_pkg::*;
#(
   parameter int NUM_PAGES        = NUM_PAGES_DEF,
   parameter int PAGE_DATA_BYTES  = PAGE_DATA_BYTES_DEF,
   parameter int PAGE_TOTAL_BYTES = PAGE_TOTAL_BYTES_DEF,
   parameter int PAGES_PER_BLOCK  = PAGES_PER_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [8] ready_res, rest zero
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   // Geometry-derived widths
   localparam int FA_DEPTH = NUM_PAGES * PAGE_TOTAL_BYTES;
   localparam int AW  = $clog2(FA_DEPTH);
   localparam int PW  = $clog2(NUM_PAGES);
   localparam int BW  = $clog2(PAGE_TOTAL_BYTES);
   localparam int CW  = $clog2(PAGE_TOTAL_BYTES + 1);
   localparam int KW  = $clog2(((NUM_PAGES > PAGES_PER_BLOCK) ? NUM_PAGES
                                : PAGES_PER_BLOCK) + 1);
   // Column / PAGE_TOTAL_BYTES as a multiply by a reciprocal, exact for 16 bits
   localparam longint RECIP = (longint'(1) << 32) / PAGE_TOTAL_BYTES + 1;
   localparam int RW  = $clog2(RECIP + 1);
   localparam int DW  = 16 + RW;

   // Control and state registers
   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [15:0]      col_ff, col_in;
   logic [15:0]      row_ff, row_in;
   logic [2:0]       acyc_ff, acyc_in;
   logic [7:0]       status_ff, status_in;
   logic [4:0]       held_ff, held_in;
   logic [CW-1:0]    pcount_ff, pcount_in;
   logic [CW-1:0]    sweep_ff, sweep_in;
   logic [KW-1:0]    page_cnt_ff, page_cnt_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [7:0]       maker_ff, device_ff;
   logic             hide_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_ready_ff, rsp_ready_in;
   logic [AW-1:0]    base_ff;
   logic [15:0]      q_ff, q_in;
   logic [BW-1:0]    wr_idx_ff, wr_idx_in;
   logic             pvalid_ff, pvalid_in;
   logic             rd_oob_ff, rd_oob_in;

   // Memory ports
   logic             fa_we, pb_we, vr_we;
   logic [AW-1:0]    fa_waddr, fa_raddr;
   logic [7:0]       fa_wdata, fa_rdata;
   logic [BW-1:0]    pb_waddr, pb_raddr;
   logic [7:0]       pb_wdata, pb_rdata;
   logic [PW-1:0]    vr_waddr, vr_raddr;
   logic             vr_wdata, vr_rdata;

   // Decode
   logic             req_accept;
   bus_kind_type     kind;
   logic             in_prog, in_read, row_ok, first_ok;
   logic [15:0]      first_page;
   logic [17:0]      erase_page;
   logic             erase_hit;
   logic             rsp_load;
   logic [DW-1:0]    div_prod;
   logic [15:0]      buf_col;
   logic [2:0]       acyc_bump;
   logic [15:0]      col_sat;

   assign req_accept = req_tvalid && req_tready;
   assign kind       = bus_kind_type'(req_tuser);
   assign in_prog    = (mode_ff == MODE_PROG) || (mode_ff == MODE_RDIN);
   assign in_read    = (mode_ff == MODE_READ) || (mode_ff == MODE_RDOUT);
   assign row_ok     = {1'b0, row_ff} < 17'(NUM_PAGES);
   assign first_page = row_ff & ~16'(PAGES_PER_BLOCK - 1);
   assign first_ok   = {1'b0, first_page} < 17'(NUM_PAGES);
   assign erase_page = 18'(first_page) + 18'(page_cnt_ff);
   assign erase_hit  = erase_page < 18'(NUM_PAGES);
   assign div_prod   = DW'(col_ff) * DW'(RECIP);
   assign buf_col    = col_ff - 16'(q_ff * PAGE_TOTAL_BYTES);
   assign acyc_bump  = (acyc_ff < ADDR_CYC_MAX) ? acyc_ff + 3'd1 : acyc_ff;
   assign col_sat    = (col_ff < COL_MAX) ? col_ff + 16'd1 : col_ff;

   // -------------------------------------------------------------------------
   // Next state
   // -------------------------------------------------------------------------
   always_comb begin : p_next_state
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (page_cnt_ff == KW'(NUM_PAGES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (kind)
                  BUS_CMD: begin
                     case (req_tdata)
                        OP_PROG1: state_in = ST_FILL;
                        OP_PROG2, OP_PROG_CACHE: begin
                           if (in_prog && row_ok) state_in = ST_PV_RD;
                        end
                        OP_ERASE2: begin
                           if ((mode_ff == MODE_ERASE) && first_ok) state_in = ST_ERASE;
                        end
                        default: state_in = ST_IDLE;
                     endcase
                  end
                  BUS_READ:  if (in_read) state_in = ST_RD_ISSUE;
                  BUS_WRITE: if (in_prog) state_in = ST_WR_DIV;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            if (sweep_ff == CW'(PAGE_TOTAL_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_PV_RD:  state_in = ST_PV_CHK;
         ST_PV_CHK: state_in = ST_PROG;
         ST_PROG: begin
            if (sweep_ff == CW'(PAGE_TOTAL_BYTES - 1)) state_in = ST_PROG_LAST;
         end
         ST_PROG_LAST: state_in = ST_IDLE;
         ST_ERASE: begin
            if (page_cnt_ff == KW'(PAGES_PER_BLOCK - 1)) state_in = ST_IDLE;
         end
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = ST_IDLE;
         ST_WR_DIV:   state_in = ST_WR_SUB;
         ST_WR_SUB:   state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // -------------------------------------------------------------------------
   // Outputs: handshake, memory ports, result load
   // -------------------------------------------------------------------------
   always_comb begin : p_outputs
      req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      fa_we    = 1'b0;
      fa_waddr = '0;
      fa_wdata = pb_rdata & (pvalid_ff ? fa_rdata : ERASED);
      fa_raddr = '0;
      pb_we    = 1'b0;
      pb_waddr = '0;
      pb_wdata = req_tdata;
      pb_raddr = '0;
      vr_we    = 1'b0;
      vr_waddr = '0;
      vr_wdata = 1'b0;
      vr_raddr = row_ff[PW-1:0];
      rsp_load = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            vr_we    = 1'b1;
            vr_waddr = page_cnt_ff[PW-1:0];
         end
         ST_IDLE: begin
            // Accesses that stay in idle answer on the accepting edge
            rsp_load = req_accept && (state_in == ST_IDLE);
         end
         ST_FILL: begin
            pb_we    = 1'b1;
            pb_waddr = sweep_ff[BW-1:0];
            pb_wdata = ERASED;
            rsp_load = (state_in == ST_IDLE);
         end
         ST_PV_CHK: begin
            // Page now holds programmed data
            vr_we    = 1'b1;
            vr_waddr = row_ff[PW-1:0];
            vr_wdata = 1'b1;
         end
         ST_PROG: begin
            pb_raddr = sweep_ff[BW-1:0];
            fa_raddr = base_ff + AW'(sweep_ff);
            fa_we    = wr_pend_ff;
            fa_waddr = base_ff + AW'(wr_idx_ff);
         end
         ST_PROG_LAST: begin
            fa_we    = wr_pend_ff;
            fa_waddr = base_ff + AW'(wr_idx_ff);
            rsp_load = 1'b1;
         end
         ST_ERASE: begin
            vr_we    = erase_hit;
            vr_waddr = erase_page[PW-1:0];
            rsp_load = (state_in == ST_IDLE);
         end
         ST_RD_ISSUE: begin
            fa_raddr = base_ff + AW'(col_ff);
         end
         ST_RD_DATA: rsp_load = 1'b1;
         ST_WR_SUB: begin
            pb_we    = pcount_ff < CW'(PAGE_TOTAL_BYTES);
            pb_waddr = buf_col[BW-1:0];
            pb_wdata = rsp_data_ff;
            rsp_load = 1'b1;
         end
         default: rsp_load = 1'b0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Datapath: command semantics and register updates
   // -------------------------------------------------------------------------
   always_comb begin : p_datapath
      mode_in     = mode_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      acyc_in     = acyc_ff;
      status_in   = status_ff;
      held_in     = held_ff;
      pcount_in   = pcount_ff;
      sweep_in    = sweep_ff;
      page_cnt_in = page_cnt_ff;
      wr_pend_in  = 1'b0;
      wr_idx_in   = sweep_ff[BW-1:0];
      q_in        = q_ff;
      pvalid_in   = pvalid_ff;
      rd_oob_in   = rd_oob_ff;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: page_cnt_in = page_cnt_ff + KW'(1);
         ST_IDLE: begin
            if (req_accept) begin
               rsp_data_in = 8'd0;
               case (kind)
                  BUS_CMD: begin
                     case (req_tdata)
                        OP_RESET: begin
                           mode_in   = MODE_IDLE;
                           status_in = (status_ff & STATUS_WP) | STATUS_READY;
                           held_in   = 5'd0;
                           acyc_in   = 3'd0;
                        end
                        OP_READ1: begin
                           mode_in = MODE_READ;
                           acyc_in = 3'd0;
                        end
                        OP_PROG1: begin
                           mode_in   = MODE_PROG;
                           acyc_in   = 3'd0;
                           pcount_in = '0;
                           sweep_in  = '0;
                        end
                        OP_PROG2, OP_PROG_CACHE: begin
                           if (in_prog) begin
                              status_in = (status_ff & STATUS_WP) | {3'd0, held_ff}
                                          | STATUS_READY;
                              held_in   = (req_tdata == OP_PROG_CACHE) ? status_in[4:0]
                                                                       : 5'd0;
                              sweep_in  = '0;
                           end
                           mode_in = MODE_IDLE;
                        end
                        OP_ERASE1: begin
                           mode_in = MODE_ERASE;
                           row_in  = 16'd0;
                           acyc_in = 3'd0;
                        end
                        OP_ERASE2: begin
                           if (mode_ff == MODE_ERASE) begin
                              status_in   = (status_ff & STATUS_WP) | STATUS_READY;
                              page_cnt_in = '0;
                           end
                           mode_in = MODE_IDLE;
                        end
                        OP_STATUS: mode_in = MODE_STATUS;
                        OP_READ_ID: begin
                           mode_in = MODE_ID;
                           acyc_in = 3'd0;
                           col_in  = 16'd0;
                        end
                        OP_READ2: begin
                           if (!((mode_ff == MODE_READ) && (acyc_ff >= ADDR_CYC_ROW)))
                              mode_in = MODE_IDLE;
                        end
                        OP_RND_OUT1: begin
                           if (in_read) begin
                              mode_in = MODE_RDOUT;
                              acyc_in = 3'd0;
                           end else begin
                              mode_in = MODE_IDLE;
                           end
                        end
                        OP_RND_OUT2: begin
                           if (mode_ff != MODE_RDOUT) mode_in = MODE_IDLE;
                        end
                        OP_RND_IN: begin
                           if (in_prog) begin
                              mode_in   = MODE_RDIN;
                              acyc_in   = 3'd0;
                              pcount_in = '0;
                           end else begin
                              mode_in = MODE_IDLE;
                           end
                        end
                        default: mode_in = MODE_IDLE;
                     endcase
                  end
                  BUS_ADDR: begin
                     case (mode_ff)
                        MODE_READ, MODE_PROG: begin
                           if (acyc_ff == 3'd0) row_in = 16'd0;
                           if (acyc_ff < 3'd2) begin
                              if (acyc_ff[0]) col_in[15:8] = req_tdata;
                              else            col_in[7:0]  = req_tdata;
                           end else if (acyc_ff < ADDR_CYC_ROW) begin
                              if (acyc_ff[0]) row_in[15:8] = req_tdata;
                              else            row_in[7:0]  = req_tdata;
                           end
                           acyc_in = acyc_bump;
                        end
                        MODE_ERASE: begin
                           if (acyc_ff < 3'd2) begin
                              if (acyc_ff[0]) row_in[15:8] = req_tdata;
                              else            row_in[7:0]  = req_tdata;
                           end
                           acyc_in = acyc_bump;
                        end
                        MODE_RDIN, MODE_RDOUT: begin
                           if (acyc_ff < 3'd2) begin
                              if (acyc_ff[0]) col_in[15:8] = req_tdata;
                              else            col_in[7:0]  = req_tdata;
                           end
                           acyc_in = acyc_bump;
                        end
                        MODE_ID: begin
                           if (acyc_ff == 3'd0) col_in = {8'd0, req_tdata};
                           acyc_in = acyc_bump;
                        end
                        default: acyc_in = acyc_ff;
                     endcase
                  end
                  BUS_WRITE: begin
                     // Hold the data byte until the buffer index is known;
                     // a write outside program modes answers zero at once
                     rsp_data_in = in_prog ? req_tdata : 8'd0;
                  end
                  BUS_READ: begin
                     case (mode_ff)
                        MODE_STATUS: rsp_data_in = status_ff & STATUS_MASK;
                        MODE_ID: begin
                           case (col_ff)
                              ID_IDX_MAKER:  rsp_data_in = maker_ff;
                              ID_IDX_DEVICE: rsp_data_in = device_ff;
                              ID_IDX_BYTE3:  rsp_data_in = ID_BYTE3;
                              default:       rsp_data_in = 8'd0;
                           endcase
                           col_in = col_sat;
                        end
                        default: rsp_data_in = 8'd0;
                     endcase
                  end
                  default: rsp_data_in = 8'd0;
               endcase
            end
         end
         ST_FILL: sweep_in = sweep_ff + CW'(1);
         ST_PV_CHK: pvalid_in = vr_rdata;
         ST_PROG: begin
            sweep_in   = sweep_ff + CW'(1);
            wr_pend_in = 1'b1;
         end
         ST_ERASE: page_cnt_in = page_cnt_ff + KW'(1);
         ST_RD_ISSUE: begin
            rd_oob_in = !((col_ff < 16'(PAGE_TOTAL_BYTES)) && row_ok)
                        || (hide_ff && (col_ff >= 16'(PAGE_DATA_BYTES)));
            col_in    = col_sat;
         end
         ST_RD_DATA: begin
            rsp_data_in = (rd_oob_ff || !vr_rdata) ? ERASED : fa_rdata;
         end
         ST_WR_DIV: q_in = 16'(div_prod >> 32);
         ST_WR_SUB: begin
            if (pcount_ff < CW'(PAGE_TOTAL_BYTES)) pcount_in = pcount_ff + CW'(1);
            col_in = (col_ff + 16'd1 == 16'(PAGE_TOTAL_BYTES)) ? 16'd0 : col_ff + 16'd1;
            rsp_data_in = 8'd0;
         end
         default: rsp_data_in = rsp_data_ff;
      endcase
      rsp_ready_in = status_in[6];
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         mode_ff      <= MODE_IDLE;
         col_ff       <= 16'd0;
         row_ff       <= 16'd0;
         acyc_ff      <= 3'd0;
         status_ff    <= STATUS_RST;
         held_ff      <= 5'd0;
         pcount_ff    <= '0;
         sweep_ff     <= '0;
         page_cnt_ff  <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         maker_ff     <= MAKER_ID_RST;
         device_ff    <= DEVICE_ID_RST;
         hide_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         acyc_ff      <= acyc_in;
         status_ff    <= status_in;
         held_ff      <= held_in;
         pcount_ff    <= pcount_in;
         sweep_ff     <= sweep_in;
         page_cnt_ff  <= page_cnt_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_MAKER_ID:   maker_ff  <= csr_wdata;
               CSR_DEVICE_ID:  device_ff <= csr_wdata;
               CSR_HIDE_SPARE: hide_ff   <= csr_wdata[0];
               default:        hide_ff   <= hide_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      // Row base is a registered copy of row_ff * PAGE_TOTAL_BYTES
      base_ff      <= AW'(row_ff * PAGE_TOTAL_BYTES);
      q_ff         <= q_in;
      wr_idx_ff    <= wr_idx_in;
      pvalid_ff    <= pvalid_in;
      rd_oob_ff    <= rd_oob_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ready_ff <= rsp_ready_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ready_ff, rsp_data_ff};

   // -------------------------------------------------------------------------
   // Memories
   // -------------------------------------------------------------------------
   nfd_ram #(.WIDTH(8), .DEPTH(FA_DEPTH)) u_flash (
      .clock    (clock),
      .we       (fa_we),
      .waddr    (fa_waddr),
      .wdata    (fa_wdata),
      .raddr    (fa_raddr),
      .rdata_ff (fa_rdata)
   );

   nfd_ram #(.WIDTH(8), .DEPTH(PAGE_TOTAL_BYTES)) u_page_buf (
      .clock    (clock),
      .we       (pb_we),
      .waddr    (pb_waddr),
      .wdata    (pb_wdata),
      .raddr    (pb_raddr),
      .rdata_ff (pb_rdata)
   );

   nfd_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_page_valid (
      .clock    (clock),
      .we       (vr_we),
      .waddr    (vr_waddr),
      .wdata    (vr_wdata),
      .raddr    (vr_raddr),
      .rdata_ff (vr_rdata)
   );

endmodule

[rtl/nfd_checker.sv]
// -----------------------------------------------------------------------------
// nfd_checker
// Port-level checks for the NAND flash device model, bound to the top level.
// -----------------------------------------------------------------------------
module nfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        csr_we,
   input logic [1:0]  csr_addr,
   input logic [7:0]  csr_wdata
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // New request only when the result slot frees up
   a_one_slot: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken over a pending result");

   // Clearing pass after reset: nothing accepted, nothing shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("activity right after reset");

   // Pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] == 7'd0)
      else $error("nonzero pad bits");

endmodule

bind nand_flash_device_model nfd_checker u_nfd_checker (.*);

[test/nand_flash_device_model_checker.sv]
// -----------------------------------------------------------------------------
// nand_flash_device_model_checker
// Watches the request, response and register ports of the flash model. It keeps
// its own copy of the array, the page buffer and the command state. Each result
// on the response channel is compared with the oldest predicted byte and ready
// bit.
// -----------------------------------------------------------------------------
module nand_flash_device_model_checker
   import nfd_pkg::*;
#(
   parameter int NUM_PAGES        = NUM_PAGES_DEF,
   parameter int PAGE_DATA_BYTES  = PAGE_DATA_BYTES_DEF,
   parameter int PAGE_TOTAL_BYTES = PAGE_TOTAL_BYTES_DEF,
   parameter int PAGES_PER_BLOCK  = PAGES_PER_BLOCK_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [7:0] read_data;
      logic       ready_res;
   } nand_result_t;

   bit [7:0]     cells [NUM_PAGES*PAGE_TOTAL_BYTES];
   bit [7:0]     page_buf [PAGE_TOTAL_BYTES];
   mode_type     mode;
   bit [15:0]    col;
   bit [15:0]    row;
   bit [2:0]     addr_cnt;
   bit [7:0]     status;
   bit [4:0]     held;
   int           load_cnt;
   bit [7:0]     maker, device;
   bit           hide_spare;
   nand_result_t expected_results [$];
   int           rsp_count;

   initial begin
      errors = 0;
      foreach (cells[i]) cells[i] = ERASED;
   end

   assign pending = expected_results.size();

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
      errors++;
   endtask

   function automatic bit [15:0] put_byte(bit [15:0] r, bit [2:0] which, bit [7:0] v);
      if (which[0]) return {v, r[7:0]};
      return {r[15:8], v};
   endfunction

   task automatic flash_command(input bit [7:0] c);
      int base;
      int first;
      int n;
      case (c)
         OP_RESET: begin
            mode = MODE_IDLE; status = (status & STATUS_WP) | STATUS_READY;
            held = 0; addr_cnt = 0;
         end
         OP_READ1: begin mode = MODE_READ; addr_cnt = 0; end
         OP_PROG1: begin
            mode = MODE_PROG; addr_cnt = 0; load_cnt = 0;
            foreach (page_buf[i]) page_buf[i] = ERASED;
         end
         OP_PROG2, OP_PROG_CACHE: begin
            if (mode == MODE_PROG || mode == MODE_RDIN) begin
               status = (status & STATUS_WP) | held;
               if (row < NUM_PAGES) begin
                  base = int'(row) * PAGE_TOTAL_BYTES;
                  for (int i = 0; i < PAGE_TOTAL_BYTES; i++) cells[base+i] &= page_buf[i];
               end
               status |= STATUS_READY;
               held = (c == OP_PROG_CACHE) ? status[4:0] : 5'd0;
            end
            mode = MODE_IDLE;
         end
         OP_ERASE1: begin mode = MODE_ERASE; row = 0; addr_cnt = 0; end
         OP_ERASE2: begin
            if (mode == MODE_ERASE) begin
               first = row & ~(PAGES_PER_BLOCK - 1);
               if (first < NUM_PAGES) begin
                  n = PAGES_PER_BLOCK;
                  if (first + n > NUM_PAGES) n = NUM_PAGES - first;
                  for (int i = 0; i < n * PAGE_TOTAL_BYTES; i++)
                     cells[first*PAGE_TOTAL_BYTES+i] = ERASED;
               end
               status = (status & STATUS_WP) | STATUS_READY;
            end
            mode = MODE_IDLE;
         end
         OP_STATUS: mode = MODE_STATUS;
         OP_READ_ID: begin mode = MODE_ID; addr_cnt = 0; col = 0; end
         OP_READ2: if (!(mode == MODE_READ && addr_cnt >= ADDR_CYC_ROW)) mode = MODE_IDLE;
         OP_RND_OUT1: begin
            if (mode == MODE_READ || mode == MODE_RDOUT) begin
               mode = MODE_RDOUT; addr_cnt = 0;
            end else mode = MODE_IDLE;
         end
         OP_RND_OUT2: if (mode != MODE_RDOUT) mode = MODE_IDLE;
         OP_RND_IN: begin
            if (mode == MODE_PROG || mode == MODE_RDIN) begin
               mode = MODE_RDIN; addr_cnt = 0; load_cnt = 0;
            end else mode = MODE_IDLE;
         end
         default: mode = MODE_IDLE;
      endcase
   endtask

   task automatic flash_access(input bit [1:0] kind, input bit [7:0] b, output bit [7:0] rd);
      rd = 0;
      case (kind)
         BUS_CMD: flash_command(b);
         BUS_ADDR: begin
            case (mode)
               MODE_READ, MODE_PROG: begin
                  if (addr_cnt == 0) row = 0;
                  if (addr_cnt < 2) col = put_byte(col, addr_cnt, b);
                  else if (addr_cnt < 4) row = put_byte(row, addr_cnt, b);
               end
               MODE_ERASE: if (addr_cnt < 2) row = put_byte(row, addr_cnt, b);
               MODE_RDIN, MODE_RDOUT: if (addr_cnt < 2) col = put_byte(col, addr_cnt, b);
               MODE_ID: if (addr_cnt == 0) col = {8'd0, b};
               default: ;
            endcase
            // count saturates; idle and status modes do not count at all
            if (mode != MODE_IDLE && mode != MODE_STATUS && addr_cnt < ADDR_CYC_MAX)
               addr_cnt++;
         end
         BUS_WRITE: begin
            if (mode == MODE_PROG || mode == MODE_RDIN) begin
               if (load_cnt < PAGE_TOTAL_BYTES) begin
                  page_buf[col % PAGE_TOTAL_BYTES] = b;
                  load_cnt++;
               end
               col = col + 1;
               if (col == PAGE_TOTAL_BYTES) col = 0;
            end
         end
         default: begin
            case (mode)
               MODE_READ, MODE_RDOUT: begin
                  rd = ERASED;
                  if (col < PAGE_TOTAL_BYTES && row < NUM_PAGES) begin
                     rd = cells[int'(row)*PAGE_TOTAL_BYTES + col];
                     if (hide_spare && col >= PAGE_DATA_BYTES) rd = ERASED;
                  end
                  if (col != COL_MAX) col++;
               end
               MODE_STATUS: rd = status & STATUS_MASK;
               MODE_ID: begin
                  case (col)
                     ID_IDX_MAKER:  rd = maker;
                     ID_IDX_DEVICE: rd = device;
                     ID_IDX_BYTE3:  rd = ID_BYTE3;
                     default:       rd = 0;
                  endcase
                  if (col != COL_MAX) col++;
               end
               default: rd = 0;
            endcase
         end
      endcase
   endtask

   always @(posedge clock) begin
      nand_result_t want;
      bit [7:0]     rd;
      if (reset) begin
         foreach (page_buf[i]) page_buf[i] = 0;
         mode = MODE_IDLE; col = 0; row = 0; addr_cnt = 0;
         status = STATUS_RST; held = 0; load_cnt = 0;
         maker = MAKER_ID_RST; device = DEVICE_ID_RST; hide_spare = 0;
         expected_results.delete();
         rsp_count = 0;
      end else begin
         // retire the response before predicting the request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report("unexpected transfer", rsp_tdata, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[7:0] !== want.read_data) report("read_data", rsp_tdata[7:0], want.read_data);
               if (rsp_tdata[8] !== want.ready_res) report("ready_res", rsp_tdata[8], want.ready_res);
               if (rsp_tdata[15:9] !== 0) report("pad", rsp_tdata[15:9], 0);
            end
            rsp_count++;
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_MAKER_ID:   maker = csr_wdata;
               CSR_DEVICE_ID:  device = csr_wdata;
               CSR_HIDE_SPARE: hide_spare = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            flash_access(req_tuser, req_tdata, rd);
            want.read_data = rd;
            want.ready_res = status[6];
            expected_results.push_back(want);
         end
      end
   end

endmodule

[test/nand_flash_device_model_tb.sv]
// -----------------------------------------------------------------------------
// nand_flash_device_model_tb
// Drives bus accesses into the flash model: directed command sequences first,
// then random page reads, loads, erases, status and ID reads mixed with noise,
// under three idling profiles and several ID and spare-hiding settings.
// -----------------------------------------------------------------------------
module nand_flash_device_model_tb;
   import nfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int RANDOM_ITEMS   = 1700;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] byte_in
   logic [1:0]  req_tuser;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] read_data, [8] ready_res
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [7:0]  csr_wdata;
   int          errors;
   int          pending;
   int          tx_idle_pct, rx_idle_pct;
   int          accesses, idle_cycles, loads, erases, page_reads;

   nand_flash_device_model uut (.*);

   nand_flash_device_model_checker checker_i (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // receiver stalls at random, per the current profile
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("[nand_flash_device_model] ERROR");
         $finish;
      end
   end

   // one bus access; hold valid until the transfer, then drop it
   task automatic bus(input bus_kind_type kind, input logic [7:0] b);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
         repeat ($urandom_range(3, 1)) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata  = 8'($urandom);
      accesses++;
   endtask

   task automatic drain;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] v);
      drain();
      csr_we = 1'b1; csr_addr = idx; csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic [15:0] pick_row();
      case ($urandom_range(9))
         0:       return 16'd1023;
         1:       return 16'd64 + 16'($urandom_range(1));
         2:       return 16'($urandom);           // mostly beyond the array
         default: return 16'($urandom_range(3));
      endcase
   endfunction

   function automatic logic [15:0] pick_col();
      case ($urandom_range(7))
         0:       return 16'd2040 + 16'($urandom_range(80));  // data end, spare, past page
         1:       return 16'hFFFE - 16'($urandom_range(1));
         2:       return 16'($urandom);
         default: return 16'($urandom_range(15));
      endcase
   endfunction

   // 00h, column and row bytes, optional extra cycles, 30h, then reads;
   // sometimes jump the column with 05h/E0h
   task automatic page_read(input logic [15:0] r, input logic [15:0] c, input int n);
      bus(BUS_CMD, OP_READ1);
      bus(BUS_ADDR, c[7:0]); bus(BUS_ADDR, c[15:8]);
      bus(BUS_ADDR, r[7:0]); bus(BUS_ADDR, r[15:8]);
      repeat ($urandom_range(4) == 0 ? $urandom_range(4, 1) : 0) bus(BUS_ADDR, 8'($urandom));
      bus(BUS_CMD, OP_READ2);
      repeat (n) bus(BUS_READ, 8'h00);
      if ($urandom_range(2) == 0) begin
         c = pick_col();
         bus(BUS_CMD, OP_RND_OUT1);
         bus(BUS_ADDR, c[7:0]); bus(BUS_ADDR, c[15:8]);
         bus(BUS_CMD, OP_RND_OUT2);
         repeat ($urandom_range(4, 1)) bus(BUS_READ, 8'h00);
      end
      page_reads++;
   endtask

   // 80h, address, data; sometimes 85h with a new column; then 10h or 15h
   task automatic page_load(input logic [15:0] r, input logic [15:0] c, input int n);
      bus(BUS_CMD, OP_PROG1);
      bus(BUS_ADDR, c[7:0]); bus(BUS_ADDR, c[15:8]);
      bus(BUS_ADDR, r[7:0]); bus(BUS_ADDR, r[15:8]);
      repeat (n) bus(BUS_WRITE, 8'($urandom));
      if ($urandom_range(3) == 0) begin
         c = pick_col();
         bus(BUS_CMD, OP_RND_IN);
         bus(BUS_ADDR, c[7:0]); bus(BUS_ADDR, c[15:8]);
         repeat ($urandom_range(6, 1)) bus(BUS_WRITE, 8'($urandom));
      end
      bus(BUS_CMD, $urandom_range(1) ? OP_PROG2 : OP_PROG_CACHE);
      loads++;
   endtask

   task automatic block_erase(input logic [15:0] r);
      bus(BUS_CMD, OP_ERASE1);
      bus(BUS_ADDR, r[7:0]); bus(BUS_ADDR, r[15:8]);
      bus(BUS_CMD, OP_ERASE2);
      erases++;
   endtask

   task automatic random_phase(input int items);
      int start;
      logic [15:0] r;
      start = accesses;
      while (accesses - start < items) begin
         r = pick_row();
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: page_read(r, pick_col(), $urandom_range(6, 1));
            6, 7, 8:          page_load(r, pick_col(), $urandom_range(8, 1));
            9:                block_erase(r);
            10: begin
               bus(BUS_CMD, OP_STATUS);
               repeat ($urandom_range(3, 1)) bus(BUS_READ, 8'($urandom));
            end
            11: begin
               bus(BUS_CMD, OP_READ_ID);
               bus(BUS_ADDR, $urandom_range(1) ? 8'h00 : 8'($urandom));
               repeat ($urandom_range(5, 1)) bus(BUS_READ, 8'h00);
            end
            12: begin
               // broken sequence: a follow-up command out of place
               bus(BUS_CMD, $urandom_range(1) ? OP_READ2 : OP_RND_IN);
               bus(BUS_READ, 8'h00);
            end
            13: bus(BUS_CMD, OP_RESET);
            default: bus(bus_kind_type'(2'($urandom_range(3))), 8'($urandom));
         endcase
         // hold off once in a while until every result is back
         if ($urandom_range(60) == 0) drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = BUS_CMD;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_addr = CSR_MAKER_ID; csr_wdata = '0;
      tx_idle_pct = 0; rx_idle_pct = 0;
      accesses = 0; idle_cycles = 0; loads = 0; erases = 0; page_reads = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed: ID, status, reads of erased pages, a program and the unusual cases
      bus(BUS_CMD, OP_READ_ID); bus(BUS_ADDR, 8'h00);
      repeat (5) bus(BUS_READ, 8'h00);
      bus(BUS_CMD, OP_STATUS); bus(BUS_READ, 8'h00);
      bus(BUS_READ, 8'h00);                 // still in status mode
      bus(BUS_CMD, 8'h65);                  // unknown command drops to idle
      bus(BUS_READ, 8'h00);
      bus(BUS_WRITE, 8'hA5);                // write outside program modes is ignored
      page_load(16'd0, 16'd2110, 4);        // wraps the column at the page end
      page_read(16'd0, 16'd2110, 4);
      page_read(16'hFFFF, 16'hFFFE, 3);     // out of range, column saturates
      block_erase(16'd0);
      bus(BUS_CMD, OP_RESET);
      drain();
      page_read(16'd0, 16'd0, 3);
      page_read(16'd0, 16'd2046, 5);

      tx_idle_pct = 32; rx_idle_pct = 65;
      csr_write(CSR_MAKER_ID, 8'h00); csr_write(CSR_DEVICE_ID, 8'hFF);
      csr_write(CSR_HIDE_SPARE, 8'h01);
      random_phase(RANDOM_ITEMS / 3);

      tx_idle_pct = 65; rx_idle_pct = 32;
      csr_write(CSR_MAKER_ID, 8'hFF); csr_write(CSR_DEVICE_ID, 8'h00);
      csr_write(CSR_HIDE_SPARE, 8'h00);
      random_phase(RANDOM_ITEMS / 3);

      tx_idle_pct = 0; rx_idle_pct = 0;
      csr_write(CSR_MAKER_ID, 8'($urandom)); csr_write(CSR_DEVICE_ID, 8'($urandom));
      csr_write(CSR_HIDE_SPARE, 8'h01);
      random_phase(RANDOM_ITEMS / 3);

      drain();
      repeat (50) @(negedge clock);
      $display("covered %0d bus accesses: %0d page reads, %0d program loads, %0d erases",
               accesses, page_reads, loads, erases);
      $display("three stall profiles, ID and spare-hiding settings at both extremes");
      if (errors == 0) begin
         $display("[nand_flash_device_model] OK");
      end else begin
         $display("[nand_flash_device_model] ERROR");
      end
      $finish;
   end

endmodule
